// ===== sv/spca_pkg.sv =====
// spca_pkg: widths, constants, register codes and shared structs for the
// stereo path cost aggregation block. No dependencies; every other file imports it.
package spca_pkg;

  localparam int MAX_DISP     = 64;
  localparam int MAX_WIDTH    = 1024;
  localparam int PATH_COUNT   = 8;
  localparam int RESULT_DEPTH = 4;

  localparam int DISP_W    = $clog2(MAX_DISP);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 10;
  localparam int IN_COST_W = 12;
  localparam int COST_W    = 13;
  localparam int SUM_W     = 16;
  localparam int PEN_W     = 12;
  localparam int DIR_W     = 3;
  localparam int LVL_W     = 7;
  localparam int CAND_W    = COST_W + 1;
  localparam int DIFF_W    = 16;

  localparam int BANK_AW = 1 + COL_W + DISP_W - 1;
  localparam int MIN_AW  = 1 + COL_W;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [COST_W-1:0] COST_MAX      = '1;
  localparam logic [PEN_W-1:0]  PEN_SMALL_RST = PEN_W'(16);
  localparam logic [PEN_W-1:0]  PEN_LARGE_RST = PEN_W'(128);
  localparam logic [DIR_W-1:0]  DIR_RST       = '0;
  localparam logic [LVL_W-1:0]  LVL_RST       = LVL_W'(64);

  typedef logic [COST_W-1:0] cost_t;

  typedef enum logic [1:0] {
    REG_PENALTY_SMALL,
    REG_PENALTY_LARGE,
    REG_DIRECTION,
    REG_DISP_LEVELS
  } spca_reg_t;

  typedef struct packed {
    logic [PEN_W-1:0] penalty_small;
    logic [PEN_W-1:0] penalty_large;
    logic [DIR_W-1:0] direction;
    logic [LVL_W-1:0] levels;
  } spca_cfg_t;

  typedef struct packed {
    logic              half;
    logic [COL_W-1:0]  col;
    logic [DISP_W-1:0] disp;
    logic [DISP_W-1:0] disp_up;
    logic [DISP_W-1:0] disp_dn;
  } spca_rd_req_t;

  typedef struct packed {
    cost_t path_d;
    cost_t path_up;
    cost_t path_dn;
    cost_t minimum;
  } spca_rd_data_t;

  typedef struct packed {
    logic              en;
    logic              half;
    logic [COL_W-1:0]  col;
    logic [DISP_W-1:0] disp;
    cost_t             path;
    cost_t             minimum;
  } spca_wr_req_t;

  typedef struct packed {
    cost_t            path_cost;
    logic [SUM_W-1:0] sum_out;
    cost_t            pixel_minimum;
  } spca_result_t;

  // column step of the predecessor pixel, modulo the line width
  function automatic logic [COL_W-1:0] col_offset(input logic [DIR_W-1:0] dir);
    logic [COL_W-1:0] step;
    unique case (dir)
      3'd0, 3'd1, 3'd3: step = '1;
      3'd2, 3'd6:       step = '0;
      3'd4, 3'd5, 3'd7: step = COL_W'(1);
    endcase
    return step;
  endfunction

  // predecessor lies in the other line half for every direction with a row step
  function automatic logic row_offset(input logic [DIR_W-1:0] dir);
    return (dir != 3'd0) && (dir != 3'd4);
  endfunction

endpackage

// ===== sv/spca_if.sv =====
// spca_in_if / spca_out_if: valid-ready channels for cost items and results.
// Depends on spca_pkg for field widths.
interface spca_in_if import spca_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IN_COST_W-1:0] cost;
  logic [SUM_W-1:0]     sum_in;
  logic [COL_W-1:0]     column;
  logic [ROW_W-1:0]     row_number;
  logic [DISP_W-1:0]    disparity;
  logic                 path_start;

  modport source (output valid, cost, sum_in, column, row_number, disparity, path_start,
                  input ready);
  modport sink (input valid, cost, sum_in, column, row_number, disparity, path_start,
                output ready);
endinterface

interface spca_out_if import spca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COST_W-1:0] path_cost;
  logic [SUM_W-1:0]  sum_out;
  logic [COST_W-1:0] pixel_minimum;

  modport source (output valid, path_cost, sum_out, pixel_minimum, input ready);
  modport sink (input valid, path_cost, sum_out, pixel_minimum, output ready);
endinterface

// ===== sv/spca_cfg_regs.sv =====
// spca_cfg_regs: APB-style register file for penalties, direction and level count.
// Depends on spca_pkg.
module spca_cfg_regs import spca_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output spca_cfg_t         regs
);

  spca_cfg_t regs_r;
  spca_reg_t reg_sel;
  logic      wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = spca_reg_t'(cfg_paddr[APB_AW-1:2]);
  assign regs       = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.penalty_small <= PEN_SMALL_RST;
      regs_r.penalty_large <= PEN_LARGE_RST;
      regs_r.direction     <= DIR_RST;
      regs_r.levels        <= LVL_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PENALTY_SMALL: regs_r.penalty_small <= cfg_pwdata[PEN_W-1:0];
        REG_PENALTY_LARGE: regs_r.penalty_large <= cfg_pwdata[PEN_W-1:0];
        REG_DIRECTION:     regs_r.direction     <= cfg_pwdata[DIR_W-1:0];
        REG_DISP_LEVELS:   regs_r.levels        <= cfg_pwdata[LVL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PENALTY_SMALL: cfg_prdata = APB_DW'(regs_r.penalty_small);
      REG_PENALTY_LARGE: cfg_prdata = APB_DW'(regs_r.penalty_large);
      REG_DIRECTION:     cfg_prdata = APB_DW'(regs_r.direction);
      REG_DISP_LEVELS:   cfg_prdata = APB_DW'(regs_r.levels);
    endcase
  end

endmodule

// ===== sv/spca_line_store.sv =====
// spca_line_store: two-row store of path costs (even/odd disparity banks, two read
// ports each) and of pixel minima, with registered reads. Depends on spca_pkg.
module spca_line_store import spca_pkg::*; (
  input  logic          clk,
  input  spca_rd_req_t  rd_req,
  input  spca_wr_req_t  wr_req,
  output spca_rd_data_t rd_data
);

  localparam int BANK_DEPTH = 2 ** BANK_AW;
  localparam int MIN_DEPTH  = 2 ** MIN_AW;

  cost_t even_mem [BANK_DEPTH];
  cost_t odd_mem  [BANK_DEPTH];
  cost_t min_mem  [MIN_DEPTH];

  logic [BANK_AW-1:0] even_a0, odd_a0, up_a, wr_a;
  logic [MIN_AW-1:0]  min_ra, min_wa;

  cost_t even_q0_r, even_q1_r, odd_q0_r, odd_q1_r, min_q_r;
  logic  d_odd_r, up_odd_r, dn_same_r;

  // own disparity and its lower neighbour always fall in opposite banks (or coincide)
  always_comb begin
    if (rd_req.disp[0]) begin
      even_a0 = {rd_req.half, rd_req.col, rd_req.disp_dn[DISP_W-1:1]};
      odd_a0  = {rd_req.half, rd_req.col, rd_req.disp[DISP_W-1:1]};
    end else begin
      even_a0 = {rd_req.half, rd_req.col, rd_req.disp[DISP_W-1:1]};
      odd_a0  = {rd_req.half, rd_req.col, rd_req.disp_dn[DISP_W-1:1]};
    end
  end

  assign up_a   = {rd_req.half, rd_req.col, rd_req.disp_up[DISP_W-1:1]};
  assign wr_a   = {wr_req.half, wr_req.col, wr_req.disp[DISP_W-1:1]};
  assign min_ra = {rd_req.half, rd_req.col};
  assign min_wa = {wr_req.half, wr_req.col};

  always_ff @(posedge clk) begin
    if (wr_req.en && !wr_req.disp[0]) begin
      even_mem[wr_a] <= wr_req.path;
    end
    even_q0_r <= even_mem[even_a0];
    even_q1_r <= even_mem[up_a];
  end

  always_ff @(posedge clk) begin
    if (wr_req.en && wr_req.disp[0]) begin
      odd_mem[wr_a] <= wr_req.path;
    end
    odd_q0_r <= odd_mem[odd_a0];
    odd_q1_r <= odd_mem[up_a];
  end

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      min_mem[min_wa] <= wr_req.minimum;
    end
    min_q_r <= min_mem[min_ra];
  end

  always_ff @(posedge clk) begin
    d_odd_r   <= rd_req.disp[0];
    up_odd_r  <= rd_req.disp_up[0];
    dn_same_r <= rd_req.disp_dn == rd_req.disp;
  end

  always_comb begin
    rd_data.path_d  = d_odd_r ? odd_q0_r : even_q0_r;
    rd_data.path_dn = dn_same_r ? rd_data.path_d : (d_odd_r ? even_q0_r : odd_q0_r);
    rd_data.path_up = up_odd_r ? odd_q1_r : even_q1_r;
    rd_data.minimum = min_q_r;
  end

endmodule

// ===== sv/spca_result_fifo.sv =====
// spca_result_fifo: small result queue that drives the output channel.
// Depends on spca_pkg and spca_out_if.
module spca_result_fifo import spca_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  spca_result_t push_data,
  output logic         pop,
  spca_out_if.source   out_chan
);

  localparam int PTR_W = $clog2(RESULT_DEPTH);

  spca_result_t     q_r [RESULT_DEPTH];
  logic [PTR_W:0]   wr_ptr_r, rd_ptr_r;
  spca_result_t     head;

  assign out_chan.valid         = wr_ptr_r != rd_ptr_r;
  assign pop                    = out_chan.valid && out_chan.ready;
  assign head                   = q_r[rd_ptr_r[PTR_W-1:0]];
  assign out_chan.path_cost     = head.path_cost;
  assign out_chan.sum_out       = head.sum_out;
  assign out_chan.pixel_minimum = head.pixel_minimum;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r[PTR_W-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

endmodule

// ===== sv/stereo_path_cost_aggregation.sv =====
// stereo_path_cost_aggregation: top level, input decode, two-stage cost pipeline.
// Depends on spca_pkg, spca_if, spca_cfg_regs, spca_line_store, spca_result_fifo.
//
// Takes one disparity element per cycle while the result queue has room, and returns
// one result per element, in order. Predecessor path costs and minima come from the
// line store, read in the transfer cycle and used in the cycle after; the most recent
// line store write is forwarded. When an element's predecessor pixel is the one the
// element just ahead of it is still computing (the first disparity of each pixel on
// horizontal paths, every element there when only one level is in use), input ready
// drops until that element leaves stage 1; all other elements are taken at one per
// cycle while the result queue has room.
// A four-entry result queue lets input continue while the output stalls.
// The line store powers up undefined and is never cleared; it must be written
// before it is read.
module stereo_path_cost_aggregation import spca_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  spca_in_if.sink           in_chan,
  spca_out_if.source        out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CNT_W = $clog2(RESULT_DEPTH + 1);
  localparam int SUMX_W = SUM_W + 1;

  spca_cfg_t     regs;
  spca_rd_req_t  rd_req;
  spca_rd_data_t rd_data;
  spca_wr_req_t  wr_req, lw_r;
  spca_result_t  push_data;

  logic             in_acc, hazard, pop;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // input decode
  logic [LVL_W-1:0]  lvl_eff;
  logic [DISP_W-1:0] lvl_top, disp_up, disp_dn;
  logic [DISP_W:0]   disp_inc;
  logic              pred_half;
  logic [COL_W-1:0]  pred_col;

  // stage 1
  logic                 s1_v_r, s1_start_r, s1_half_r, s1_ph_r;
  logic [IN_COST_W-1:0] s1_cost_r;
  logic [SUM_W-1:0]     s1_sum_r;
  logic [COL_W-1:0]     s1_col_r, s1_pc_r;
  logic [DISP_W-1:0]    s1_disp_r, s1_dp_r, s1_dn_r;
  logic                 fwd_pix;
  cost_t                lp_d, lp_up, lp_dn, mp;
  logic [CAND_W-1:0]    cand_d, cand_up, cand_dn, cand_mp, min_a, min_b, best;

  // stage 2
  logic                 s2_v_r, s2_start_r, s2_half_r;
  logic [IN_COST_W-1:0] s2_cost_r;
  logic [SUM_W-1:0]     s2_sum_r;
  logic [COL_W-1:0]     s2_col_r;
  logic [DISP_W-1:0]    s2_disp_r;
  logic [CAND_W-1:0]    s2_best_r;
  cost_t                s2_mp_r;
  logic [DIFF_W-1:0]    diff;
  cost_t                path, base, run_min_r, run_min_nxt;
  logic [SUMX_W-1:0]    add_val, sum_ext;
  logic [SUM_W-1:0]     sum_nxt;

  spca_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .regs        (regs)
  );

  // ---------------- input decode and line store read ----------------
  always_comb begin
    if (regs.levels == '0) begin
      lvl_eff = LVL_W'(1);
    end else if (regs.levels > LVL_W'(MAX_DISP)) begin
      lvl_eff = LVL_W'(MAX_DISP);
    end else begin
      lvl_eff = regs.levels;
    end
    lvl_top  = DISP_W'(lvl_eff - LVL_W'(1));
    disp_inc = (DISP_W + 1)'(in_chan.disparity) + 1'b1;
    disp_up  = (disp_inc < (DISP_W + 1)'(lvl_top)) ? disp_inc[DISP_W-1:0] : lvl_top;
    disp_dn  = (in_chan.disparity == '0) ? '0 : in_chan.disparity - 1'b1;
    pred_half = in_chan.row_number[0] ^ row_offset(regs.direction);
    pred_col  = in_chan.column + col_offset(regs.direction);
  end

  assign rd_req = '{half: pred_half, col: pred_col, disp: in_chan.disparity,
                    disp_up: disp_up, disp_dn: disp_dn};

  // predecessor still in stage 1: its write lands too late to forward
  assign hazard = s1_v_r && !in_chan.path_start && (s1_half_r == pred_half) &&
                  (s1_col_r == pred_col);
  assign in_chan.ready = (cnt_r < CNT_W'(RESULT_DEPTH)) && !hazard;
  assign in_acc        = in_chan.valid && in_chan.ready;

  spca_line_store u_store (
    .clk     (clk),
    .rd_req  (rd_req),
    .wr_req  (wr_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_cost_r  <= in_chan.cost;
    s1_sum_r   <= in_chan.sum_in;
    s1_col_r   <= in_chan.column;
    s1_half_r  <= in_chan.row_number[0];
    s1_disp_r  <= in_chan.disparity;
    s1_start_r <= in_chan.path_start;
    s1_ph_r    <= pred_half;
    s1_pc_r    <= pred_col;
    s1_dp_r    <= disp_up;
    s1_dn_r    <= disp_dn;
  end

  // ---------------- stage 1: forwarding and candidate minimum ----------------
  always_comb begin
    fwd_pix = lw_r.en && (lw_r.half == s1_ph_r) && (lw_r.col == s1_pc_r);
    mp      = fwd_pix ? lw_r.minimum : rd_data.minimum;
    lp_d    = (fwd_pix && lw_r.disp == s1_disp_r) ? lw_r.path : rd_data.path_d;
    lp_up   = (fwd_pix && lw_r.disp == s1_dp_r) ? lw_r.path : rd_data.path_up;
    lp_dn   = (fwd_pix && lw_r.disp == s1_dn_r) ? lw_r.path : rd_data.path_dn;
    cand_d  = CAND_W'(lp_d);
    cand_up = CAND_W'(lp_up) + CAND_W'(regs.penalty_small);
    cand_dn = CAND_W'(lp_dn) + CAND_W'(regs.penalty_small);
    cand_mp = CAND_W'(mp) + CAND_W'(regs.penalty_large);
    min_a   = (cand_up < cand_d) ? cand_up : cand_d;
    min_b   = (cand_mp < cand_dn) ? cand_mp : cand_dn;
    best    = (min_b < min_a) ? min_b : min_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_cost_r  <= s1_cost_r;
    s2_sum_r   <= s1_sum_r;
    s2_col_r   <= s1_col_r;
    s2_half_r  <= s1_half_r;
    s2_disp_r  <= s1_disp_r;
    s2_start_r <= s1_start_r;
    s2_best_r  <= best;
    s2_mp_r    <= mp;
  end

  // ---------------- stage 2: path cost, pixel minimum, sum ----------------
  always_comb begin
    diff = DIFF_W'(s2_cost_r) + DIFF_W'(s2_best_r) - DIFF_W'(s2_mp_r);
    if (s2_start_r) begin
      path = COST_W'(s2_cost_r);
    end else if (diff[DIFF_W-1]) begin
      path = '0;
    end else if (diff > DIFF_W'(COST_MAX)) begin
      path = COST_MAX;
    end else begin
      path = diff[COST_W-1:0];
    end

    base        = (s2_disp_r == '0) ? COST_MAX : run_min_r;
    run_min_nxt = (path < base) ? path : base;

    add_val = s2_start_r ? SUMX_W'(s2_cost_r) * SUMX_W'(PATH_COUNT) : SUMX_W'(path);
    sum_ext = SUMX_W'(s2_sum_r) + add_val;
    sum_nxt = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  end

  assign wr_req = '{en: s2_v_r, half: s2_half_r, col: s2_col_r, disp: s2_disp_r,
                    path: path, minimum: run_min_nxt};
  assign push_data = '{path_cost: path, sum_out: sum_nxt, pixel_minimum: run_min_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_r <= COST_MAX;
      lw_r.en   <= 1'b0;
    end else begin
      if (s2_v_r) run_min_r <= run_min_nxt;
      if (wr_req.en) lw_r <= wr_req;
    end
  end

  spca_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_v_r),
    .push_data (push_data),
    .pop       (pop),
    .out_chan  (out_chan)
  );

  // items in flight, bounded by the queue depth
  always_comb begin
    case ({in_acc, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/spca_checker.sv =====
// spca_checker: port-level assertions for stereo_path_cost_aggregation, bound
// to the top level below. Depends on spca_pkg.
module spca_checker import spca_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [COST_W-1:0] path_cost,
  input logic [SUM_W-1:0]  sum_out,
  input logic [COST_W-1:0] pixel_minimum,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic              cfg_pready,
  input logic [APB_AW-1:0] cfg_paddr,
  input logic [APB_DW-1:0] cfg_pwdata,
  input logic [APB_DW-1:0] cfg_prdata
);

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && !$past(out_ready) |->
      $stable(path_cost) && $stable(sum_out) && $stable(pixel_minimum))
    else $error("result changed while stalled");

  // the pixel minimum includes the element's own path cost
  a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pixel_minimum <= path_cost)
    else $error("pixel minimum above path cost");

  // nothing left in the result queue after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result pending right after reset");

  // a small penalty write is visible to a read of the same register that directly follows it
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) &&
    $past(cfg_paddr[APB_AW-1:2] == REG_PENALTY_SMALL) &&
    cfg_psel && !cfg_pwrite && cfg_paddr[APB_AW-1:2] == REG_PENALTY_SMALL |->
      cfg_prdata[PEN_W-1:0] == $past(cfg_pwdata[PEN_W-1:0]))
    else $error("penalty register readback mismatch");

endmodule

bind stereo_path_cost_aggregation spca_checker u_spca_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .path_cost     (out_chan.path_cost),
  .sum_out       (out_chan.sum_out),
  .pixel_minimum (out_chan.pixel_minimum),
  .cfg_psel      (cfg_psel),
  .cfg_penable   (cfg_penable),
  .cfg_pwrite    (cfg_pwrite),
  .cfg_pready    (cfg_pready),
  .cfg_paddr     (cfg_paddr),
  .cfg_pwdata    (cfg_pwdata),
  .cfg_prdata    (cfg_prdata)
);

// ===== test/spca_path_cost_checker.sv =====
`timescale 1ns / 1ps
// spca_path_cost_checker: watches the cost, result and register ports of the path cost
// aggregation block, predicts every result and compares it. Depends on spca_pkg, spca_if.
module spca_path_cost_checker import spca_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  spca_in_if                in_mon,
  spca_out_if               out_mon,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output int                fail_count,
  output int                pending_count
);

  // predecessor column step per direction (modulo line width) and row step as a bit mask
  localparam logic [COL_W-1:0] PRED_COL_STEP [8] = '{
    COL_W'(-1), COL_W'(-1), COL_W'(0), COL_W'(-1), COL_W'(1), COL_W'(1), COL_W'(0), COL_W'(1)
  };
  localparam logic [7:0] PRED_ROW_STEP = 8'b1110_1110;

  logic [PEN_W-1:0] penalty_small;
  logic [PEN_W-1:0] penalty_large;
  logic [DIR_W-1:0] direction;
  logic [LVL_W-1:0] levels;
  cost_t            pixel_min;

  cost_t line_cost [2][MAX_WIDTH][MAX_DISP];
  cost_t line_min  [2][MAX_WIDTH];

  spca_result_t expected_costs [$];
  spca_result_t predicted;
  spca_result_t oldest;

  task automatic aggregate_element(input logic [IN_COST_W-1:0] c, input logic [SUM_W-1:0] s,
                                   input logic [COL_W-1:0] col, input logic half,
                                   input logic [DISP_W-1:0] d, input logic begins_path,
                                   output spca_result_t res);
    int               lv;
    int               up;
    int               dn;
    int               prev_min;
    int               best;
    int               path;
    int               total;
    logic             ph;
    logic [COL_W-1:0] pc;
    lv = (levels == 0) ? 1 : ((levels > MAX_DISP) ? MAX_DISP : int'(levels));
    if (d == 0) pixel_min = COST_MAX;
    if (begins_path) begin
      path  = int'(c);
      total = int'(s) + PATH_COUNT * int'(c);
    end else begin
      ph       = half ^ PRED_ROW_STEP[direction];
      pc       = col + PRED_COL_STEP[direction];
      up       = (int'(d) + 1 < lv - 1) ? int'(d) + 1 : lv - 1;
      dn       = (d > 0) ? int'(d) - 1 : 0;
      prev_min = int'(line_min[ph][pc]);
      best     = int'(line_cost[ph][pc][d]);
      if (int'(line_cost[ph][pc][up]) + int'(penalty_small) < best)
        best = int'(line_cost[ph][pc][up]) + int'(penalty_small);
      if (int'(line_cost[ph][pc][dn]) + int'(penalty_small) < best)
        best = int'(line_cost[ph][pc][dn]) + int'(penalty_small);
      if (prev_min + int'(penalty_large) < best) best = prev_min + int'(penalty_large);
      path = int'(c) + best - prev_min;
      if (path < 0) path = 0;
      if (path > int'(COST_MAX)) path = int'(COST_MAX);
      total = int'(s) + path;
    end
    if (total > 65535) total = 65535;
    if (path < int'(pixel_min)) pixel_min = cost_t'(path);
    line_cost[half][col][d] = cost_t'(path);
    line_min[half][col]     = pixel_min;
    res.path_cost     = cost_t'(path);
    res.sum_out       = SUM_W'(total);
    res.pixel_minimum = pixel_min;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      penalty_small = PEN_SMALL_RST;
      penalty_large = PEN_LARGE_RST;
      direction     = DIR_RST;
      levels        = LVL_RST;
      pixel_min     = COST_MAX;
      fail_count    = 0;
      expected_costs.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (spca_reg_t'(cfg_paddr[3:2]))
          REG_PENALTY_SMALL: penalty_small = cfg_pwdata[PEN_W-1:0];
          REG_PENALTY_LARGE: penalty_large = cfg_pwdata[PEN_W-1:0];
          REG_DIRECTION:     direction     = cfg_pwdata[DIR_W-1:0];
          REG_DISP_LEVELS:   levels        = cfg_pwdata[LVL_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        aggregate_element(in_mon.cost, in_mon.sum_in, in_mon.column, in_mon.row_number[0],
                          in_mon.disparity, in_mon.path_start, predicted);
        expected_costs.push_back(predicted);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_costs.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual %0d %0d %0d", $time,
                   out_mon.path_cost, out_mon.sum_out, out_mon.pixel_minimum);
        end else begin
          oldest = expected_costs.pop_front();
          compare_field("path_cost", oldest.path_cost, out_mon.path_cost);
          compare_field("sum_out", oldest.sum_out, out_mon.sum_out);
          compare_field("pixel_minimum", oldest.pixel_minimum, out_mon.pixel_minimum);
        end
      end
    end
    pending_count = expected_costs.size();
  end

endmodule

// ===== test/stereo_path_cost_aggregation_tb.sv =====
`timescale 1ns / 1ps
// stereo_path_cost_aggregation_tb: drives cost elements, register writes and output
// stalls into the path cost aggregation block; spca_path_cost_checker judges the results.
// Depends on spca_pkg, spca_if, stereo_path_cost_aggregation, spca_path_cost_checker.
module stereo_path_cost_aggregation_tb;
  import spca_pkg::*;

  localparam int ITEM_TARGET   = 1550;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 20;

  localparam logic [COL_W-1:0] PRED_COL_STEP [8] = '{
    COL_W'(-1), COL_W'(-1), COL_W'(0), COL_W'(-1), COL_W'(1), COL_W'(1), COL_W'(0), COL_W'(1)
  };
  localparam logic [7:0] PRED_ROW_STEP = 8'b1110_1110;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  spca_in_if  in_chan ();
  spca_out_if out_chan ();

  int fail_count;
  int pending_count;
  int tx_idle_pct  = 31;
  int rx_idle_pct  = 51;
  int items_sent   = 0;
  int quiet_cycles = 0;

  logic [DIR_W-1:0] cur_dir;
  logic [LVL_W-1:0] cur_levels;

  // which line store entries hold data, so no element reads one that was never written
  bit cost_written [2][MAX_WIDTH][MAX_DISP];
  bit min_written  [2][MAX_WIDTH];

  stereo_path_cost_aggregation dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  spca_path_cost_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_pready    (cfg_pready),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #1 clk = ~clk;

  always @(negedge clk) out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("stereo_path_cost_aggregation_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int active_levels();
    return (cur_levels == 0) ? 1 : ((cur_levels > MAX_DISP) ? MAX_DISP : int'(cur_levels));
  endfunction

  function automatic bit predecessor_written(input logic [COL_W-1:0] col, input logic half,
                                             input logic [DISP_W-1:0] d);
    int               lv;
    int               up;
    int               dn;
    logic             ph;
    logic [COL_W-1:0] pc;
    lv = active_levels();
    ph = half ^ PRED_ROW_STEP[cur_dir];
    pc = col + PRED_COL_STEP[cur_dir];
    up = (int'(d) + 1 < lv - 1) ? int'(d) + 1 : lv - 1;
    dn = (d > 0) ? int'(d) - 1 : 0;
    return min_written[ph][pc] && cost_written[ph][pc][d] && cost_written[ph][pc][up] &&
           cost_written[ph][pc][dn];
  endfunction

  function automatic logic [IN_COST_W-1:0] rand_cost();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return IN_COST_W'($urandom);
      default: return IN_COST_W'($urandom_range(400));
    endcase
  endfunction

  function automatic logic [SUM_W-1:0] rand_sum();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return SUM_W'($urandom_range(60000, 65535));
      default: return SUM_W'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge after the transfer
  task automatic send_element(input logic [IN_COST_W-1:0] cost, input logic [SUM_W-1:0] sum,
                              input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                              input logic [DISP_W-1:0] d, input logic begins_path);
    logic fresh;
    fresh = begins_path || !predecessor_written(col, row[0], d);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.cost       <= cost;
    in_chan.sum_in     <= sum;
    in_chan.column     <= col;
    in_chan.row_number <= row;
    in_chan.disparity  <= d;
    in_chan.path_start <= fresh;
    do @(posedge clk); while (!in_chan.ready);
    cost_written[row[0]][col][d] = 1'b1;
    min_written[row[0]][col]     = 1'b1;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  task automatic write_reg(input spca_reg_t idx, input int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_AW'({idx, 2'b00});
    cfg_pwdata  <= APB_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    case (idx)
      REG_DIRECTION:   cur_dir    = DIR_W'(value);
      REG_DISP_LEVELS: cur_levels = LVL_W'(value);
      default: ;
    endcase
  endtask

  task automatic configure(input int p_small, input int p_large, input int dir, input int lv);
    wait_drained();
    repeat (4) @(negedge clk);
    write_reg(REG_PENALTY_SMALL, p_small);
    write_reg(REG_PENALTY_LARGE, p_large);
    write_reg(REG_DIRECTION, dir);
    write_reg(REG_DISP_LEVELS, lv);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // rows of pixels in an order where each predecessor already went through
  task automatic stream_image(input bit hold_midway);
    int               lv;
    int               width;
    int               rows;
    int               first_d;
    int               last_d;
    bit               edge_pixel;
    bit               fresh;
    logic [ROW_W-1:0] row0;
    logic [COL_W-1:0] col0;
    logic [COL_W-1:0] col;
    lv = active_levels();
    if (lv > 16) begin
      width = 2;
      rows  = 2;
    end else begin
      width = $urandom_range(2, 6);
      rows  = $urandom_range(2, 4);
    end
    row0 = ROW_W'($urandom);
    col0 = COL_W'($urandom);
    for (int r = 0; r < rows; r++) begin
      for (int p = 0; p < width; p++) begin
        if (hold_midway && r == 1 && p == 0) wait_drained();
        col = (PRED_COL_STEP[cur_dir] == COL_W'(1)) ? col0 + COL_W'(width - 1 - p)
                                                     : col0 + COL_W'(p);
        edge_pixel = (PRED_ROW_STEP[cur_dir] && r == 0) ||
                     (PRED_COL_STEP[cur_dir] != '0 && p == 0);
        fresh   = edge_pixel ? ($urandom_range(3) != 0) : ($urandom_range(31) == 0);
        first_d = 0;
        last_d  = lv - 1;
        case ($urandom_range(15))
          0: first_d = $urandom_range(lv - 1);
          1: last_d = $urandom_range(lv - 1);
          2: send_element(rand_cost(), rand_sum(),
                          $urandom_range(1) ? col0 + COL_W'($urandom_range(7)) : COL_W'($urandom),
                          ROW_W'($urandom), DISP_W'($urandom), 1'($urandom_range(1)));
          default: ;
        endcase
        for (int d = first_d; d <= last_d; d++)
          send_element(rand_cost(), rand_sum(), col, row0 + ROW_W'(r), DISP_W'(d), fresh);
      end
    end
  endtask

  task automatic directed_elements();
    // first transfer without a disparity zero ahead of it, sum saturates
    send_element(12'd4095, 16'd65535, 10'd1023, 10'd1023, 6'd5, 1'b1);
    configure(16, 128, 0, 3);
    send_element(12'd4095, 16'd0, 10'd1023, 10'd1023, 6'd0, 1'b1);
    send_element(12'd0, 16'd65535, 10'd1023, 10'd1023, 6'd1, 1'b1);
    send_element(12'd2048, 16'd100, 10'd1023, 10'd1023, 6'd2, 1'b1);
    // column zero takes its predecessor from the far edge of the line
    send_element(12'd0, 16'd65535, 10'd0, 10'd1023, 6'd0, 1'b0);
    send_element(12'd4095, 16'd0, 10'd0, 10'd1023, 6'd1, 1'b0);
    send_element(12'd1, 16'd65000, 10'd0, 10'd1023, 6'd2, 1'b0);
    // disparity past the level count
    send_element(12'd300, 16'd0, 10'd0, 10'd1023, 6'd63, 1'b1);
    send_element(12'd5, 16'd7, 10'd1, 10'd1023, 6'd0, 1'b0);
    send_element(12'd4095, 16'd65535, 10'd1, 10'd1023, 6'd1, 1'b0);
    send_element(12'd0, 16'd0, 10'd1, 10'd1023, 6'd2, 1'b0);
    // raise the stored minimum above a stale neighbour so the path cost clamps at zero
    send_element(12'd4000, 16'd0, 10'd1, 10'd1023, 6'd0, 1'b1);
    send_element(12'd4000, 16'd0, 10'd1, 10'd1023, 6'd1, 1'b1);
    send_element(12'd0, 16'd1, 10'd2, 10'd1023, 6'd1, 1'b0);
  endtask

  initial begin
    int seg;
    int p_small;
    int p_large;
    int dir;
    int lv;
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.cost       = '0;
    in_chan.sum_in     = '0;
    in_chan.column     = '0;
    in_chan.row_number = '0;
    in_chan.disparity  = '0;
    in_chan.path_start = 1'b0;
    out_chan.ready     = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    cur_dir            = DIR_RST;
    cur_levels         = LVL_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed_elements();
    seg = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent < ITEM_TARGET / 3) begin
        tx_idle_pct = 31;
        rx_idle_pct = 51;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        tx_idle_pct = 51;
        rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (seg)
        0: begin p_small = 0;    p_large = 0;    dir = 1; lv = 1;   end
        1: begin p_small = 4095; p_large = 4095; dir = 4; lv = 64;  end
        2: begin p_small = 16;   p_large = 4095; dir = 2; lv = 0;   end
        3: begin p_small = 4095; p_large = 0;    dir = 5; lv = 127; end
        4: begin p_small = 8;    p_large = 200;  dir = 3; lv = 2;   end
        default: begin
          case ($urandom_range(7))
            0:       p_small = 0;
            1:       p_small = 4095;
            default: p_small = $urandom_range(64);
          endcase
          case ($urandom_range(7))
            0:       p_large = 0;
            1:       p_large = 4095;
            default: p_large = $urandom_range(512);
          endcase
          dir = $urandom_range(7);
          case ($urandom_range(9))
            0:       lv = 0;
            1:       lv = 64;
            2:       lv = $urandom_range(65, 127);
            default: lv = $urandom_range(1, 8);
          endcase
        end
      endcase
      configure(p_small, p_large, dir, lv);
      stream_image(seg % 4 == 1);
      seg++;
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("stereo_path_cost_aggregation_tb: clean");
    end else begin
      $display("stereo_path_cost_aggregation_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/spca_pkg.sv
sv/spca_if.sv
sv/spca_cfg_regs.sv
sv/spca_line_store.sv
sv/spca_result_fifo.sv
sv/stereo_path_cost_aggregation.sv
sv/spca_checker.sv
test/spca_path_cost_checker.sv
test/stereo_path_cost_aggregation_tb.sv
